// File: hw/rtl/segment_intersection_point_macros.svh
// assertion macros shared by sip_div and segment_intersection_point
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a holds at an edge, so b holds at that same edge
`define SIP_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: %m");

// a holds at an edge, so b holds after the delay given by n
`define SIP_ASSERT_DELAY(label, clk, rst_n, a, n, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
		else $error("assertion failed: %m");

`else

`define SIP_ASSERT_IMPL(label, clk, rst_n, a, b)
`define SIP_ASSERT_DELAY(label, clk, rst_n, a, n, b)

`endif

`endif

// File: hw/rtl/sip_pkg.sv
package sip_pkg;

	// per-word outcome flags that ride along the pipeline
	typedef struct packed {
		logic hit;
		logic degenerate;
	} sip_flags_t;

endpackage

// File: hw/rtl/sip_cross.sv
module sip_cross import sip_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_vld,
	input  logic signed [COORD_BITS-1:0]    a_start_x,
	input  logic signed [COORD_BITS-1:0]    a_start_y,
	input  logic signed [COORD_BITS-1:0]    a_end_x,
	input  logic signed [COORD_BITS-1:0]    a_end_y,
	input  logic signed [COORD_BITS-1:0]    b_start_x,
	input  logic signed [COORD_BITS-1:0]    b_start_y,
	input  logic signed [COORD_BITS-1:0]    b_end_x,
	input  logic signed [COORD_BITS-1:0]    b_end_y,
	output logic                            vld_s3,
	output logic signed [2*COORD_BITS+2:0]  ca1_s3,
	output logic signed [2*COORD_BITS+2:0]  ca2_s3,
	output logic signed [2*COORD_BITS+2:0]  cb1_s3,
	output logic signed [2*COORD_BITS+2:0]  cb2_s3,
	output logic signed [COORD_BITS:0]      adx_s3,
	output logic signed [COORD_BITS:0]      ady_s3,
	output logic signed [COORD_BITS-1:0]    asx_s3,
	output logic signed [COORD_BITS-1:0]    asy_s3
);

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	// stage 1: edge vectors and endpoint offsets
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] adx_s1, ady_s1, bdx_s1, bdy_s1;
	logic signed [DIFF_W-1:0] p1x_s1, p1y_s1, p2x_s1, p2y_s1;
	logic signed [DIFF_W-1:0] q1x_s1, q1y_s1, q2x_s1, q2y_s1;
	logic signed [COORD_BITS-1:0] asx_s1, asy_s1;

	// stage 2: partial products of the four cross products
	logic                     vld_s2;
	logic signed [PROD_W-1:0] ca1l_s2, ca1r_s2, ca2l_s2, ca2r_s2;
	logic signed [PROD_W-1:0] cb1l_s2, cb1r_s2, cb2l_s2, cb2r_s2;
	logic signed [DIFF_W-1:0] adx_s2, ady_s2;
	logic signed [COORD_BITS-1:0] asx_s2, asy_s2;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// differences
	always_ff @(posedge clk) begin
		adx_s1 <= DIFF_W'(a_end_x) - DIFF_W'(a_start_x);
		ady_s1 <= DIFF_W'(a_end_y) - DIFF_W'(a_start_y);
		bdx_s1 <= DIFF_W'(b_end_x) - DIFF_W'(b_start_x);
		bdy_s1 <= DIFF_W'(b_end_y) - DIFF_W'(b_start_y);
		p1x_s1 <= DIFF_W'(b_start_x) - DIFF_W'(a_start_x);
		p1y_s1 <= DIFF_W'(b_start_y) - DIFF_W'(a_start_y);
		p2x_s1 <= DIFF_W'(b_end_x) - DIFF_W'(a_start_x);
		p2y_s1 <= DIFF_W'(b_end_y) - DIFF_W'(a_start_y);
		q1x_s1 <= DIFF_W'(a_start_x) - DIFF_W'(b_start_x);
		q1y_s1 <= DIFF_W'(a_start_y) - DIFF_W'(b_start_y);
		q2x_s1 <= DIFF_W'(a_end_x) - DIFF_W'(b_start_x);
		q2y_s1 <= DIFF_W'(a_end_y) - DIFF_W'(b_start_y);
		asx_s1 <= a_start_x;
		asy_s1 <= a_start_y;
	end

	// products
	always_ff @(posedge clk) begin
		ca1l_s2 <= PROD_W'(adx_s1) * PROD_W'(p1y_s1);
		ca1r_s2 <= PROD_W'(ady_s1) * PROD_W'(p1x_s1);
		ca2l_s2 <= PROD_W'(adx_s1) * PROD_W'(p2y_s1);
		ca2r_s2 <= PROD_W'(ady_s1) * PROD_W'(p2x_s1);
		cb1l_s2 <= PROD_W'(bdx_s1) * PROD_W'(q1y_s1);
		cb1r_s2 <= PROD_W'(bdy_s1) * PROD_W'(q1x_s1);
		cb2l_s2 <= PROD_W'(bdx_s1) * PROD_W'(q2y_s1);
		cb2r_s2 <= PROD_W'(bdy_s1) * PROD_W'(q2x_s1);
		adx_s2  <= adx_s1;
		ady_s2  <= ady_s1;
		asx_s2  <= asx_s1;
		asy_s2  <= asy_s1;
	end

	// cross products
	always_ff @(posedge clk) begin
		ca1_s3 <= CROSS_W'(ca1l_s2) - CROSS_W'(ca1r_s2);
		ca2_s3 <= CROSS_W'(ca2l_s2) - CROSS_W'(ca2r_s2);
		cb1_s3 <= CROSS_W'(cb1l_s2) - CROSS_W'(cb1r_s2);
		cb2_s3 <= CROSS_W'(cb2l_s2) - CROSS_W'(cb2r_s2);
		adx_s3 <= adx_s2;
		ady_s3 <= ady_s2;
		asx_s3 <= asx_s2;
		asy_s3 <= asy_s2;
	end

endmodule

// File: hw/rtl/sip_ratio.sv
module sip_ratio import sip_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    vld_s3,
	input  logic signed [2*COORD_BITS+2:0]          ca1_s3,
	input  logic signed [2*COORD_BITS+2:0]          ca2_s3,
	input  logic signed [2*COORD_BITS+2:0]          cb1_s3,
	input  logic signed [2*COORD_BITS+2:0]          cb2_s3,
	input  logic signed [COORD_BITS:0]              adx_s3,
	input  logic signed [COORD_BITS:0]              ady_s3,
	input  logic signed [COORD_BITS-1:0]            asx_s3,
	input  logic signed [COORD_BITS-1:0]            asy_s3,
	output logic                                    vld_s6,
	output logic [3*COORD_BITS+FRAC_BITS+5:0]       num_x_s6,
	output logic [3*COORD_BITS+FRAC_BITS+5:0]       num_y_s6,
	output logic [2*COORD_BITS+4:0]                 den_s6,
	output sip_flags_t                              flags_s6,
	output logic                                    neg_x_s6,
	output logic                                    neg_y_s6,
	output logic signed [COORD_BITS-1:0]            asx_s6,
	output logic signed [COORD_BITS-1:0]            asy_s6
);

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int MAG_W   = CROSS_W;
	localparam int SUM_W   = MAG_W + 1;
	localparam int M_W     = DIFF_W + MAG_W;
	localparam int NUM_W   = M_W + FRAC_BITS + 2;
	localparam int DEN_W   = SUM_W + 1;

	logic             hit_c;
	logic [MAG_W-1:0] l_c, r_c;

	// strict opposite-side tests on both segments
	assign hit_c = (ca1_s3 != '0) && (ca2_s3 != '0) &&
		(ca1_s3[CROSS_W-1] ^ ca2_s3[CROSS_W-1]) &&
		(cb1_s3 != '0) && (cb2_s3 != '0) &&
		(cb1_s3[CROSS_W-1] ^ cb2_s3[CROSS_W-1]);

	// distances of A's endpoints from line B
	assign l_c = cb1_s3[CROSS_W-1] ? MAG_W'(-cb1_s3) : MAG_W'(cb1_s3);
	assign r_c = cb2_s3[CROSS_W-1] ? MAG_W'(-cb2_s3) : MAG_W'(cb2_s3);

	logic                         vld_s4, vld_s5;
	logic                         hit_s4, hit_s5;
	logic [MAG_W-1:0]             l_s4;
	logic [SUM_W-1:0]             sum_s4, sum_s5;
	logic [DIFF_W-1:0]            mdx_s4, mdy_s4;
	logic                         neg_x_s4, neg_y_s4, neg_x_s5, neg_y_s5;
	logic signed [COORD_BITS-1:0] asx_s4, asy_s4, asx_s5, asy_s5;
	logic [M_W-1:0]               mx_s5, my_s5;
	logic                         degen_s5;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// stage 4: ratio terms and edge magnitudes
	always_ff @(posedge clk) begin
		hit_s4   <= hit_c;
		l_s4     <= l_c;
		sum_s4   <= SUM_W'(l_c) + SUM_W'(r_c);
		neg_x_s4 <= adx_s3[DIFF_W-1];
		neg_y_s4 <= ady_s3[DIFF_W-1];
		mdx_s4   <= adx_s3[DIFF_W-1] ? DIFF_W'(-adx_s3) : DIFF_W'(adx_s3);
		mdy_s4   <= ady_s3[DIFF_W-1] ? DIFF_W'(-ady_s3) : DIFF_W'(ady_s3);
		asx_s4   <= asx_s3;
		asy_s4   <= asy_s3;
	end

	// stage 5: scale edge magnitudes by the distance of A's start
	always_ff @(posedge clk) begin
		mx_s5    <= M_W'(mdx_s4) * M_W'(l_s4);
		my_s5    <= M_W'(mdy_s4) * M_W'(l_s4);
		sum_s5   <= sum_s4;
		degen_s5 <= (sum_s4 == '0);
		hit_s5   <= hit_s4;
		neg_x_s5 <= neg_x_s4;
		neg_y_s5 <= neg_y_s4;
		asx_s5   <= asx_s4;
		asy_s5   <= asy_s4;
	end

	// stage 6: rounded dividend and doubled divisor
	always_ff @(posedge clk) begin
		num_x_s6            <= (NUM_W'(mx_s5) << (FRAC_BITS + 1)) + NUM_W'(sum_s5);
		num_y_s6            <= (NUM_W'(my_s5) << (FRAC_BITS + 1)) + NUM_W'(sum_s5);
		den_s6              <= DEN_W'(sum_s5) << 1;
		flags_s6.hit        <= hit_s5;
		flags_s6.degenerate <= degen_s5;
		neg_x_s6            <= neg_x_s5;
		neg_y_s6            <= neg_y_s5;
		asx_s6              <= asx_s5;
		asy_s6              <= asy_s5;
	end

endmodule

// File: hw/rtl/sip_div.sv
`include "segment_intersection_point_macros.svh"

module sip_div import sip_pkg::*; #(
	parameter int NUM_W = 59,
	parameter int DEN_W = 37,
	parameter int QUO_W = 25,
	parameter int TAG_W = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [QUO_W-1:0] quo,
	output logic [TAG_W-1:0] out_tag
);

	// one quotient bit per stage; acc shifts dividend bits out and quotient bits in
	logic             vld_s [1:QUO_W];
	logic [DEN_W-1:0] rem_s [1:QUO_W];
	logic [QUO_W-1:0] acc_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [TAG_W-1:0] tag_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic             vin;
		logic [DEN_W-1:0] rin, din;
		logic [QUO_W-1:0] ain;
		logic [TAG_W-1:0] tin;
		logic [DEN_W:0]   trial, diff;

		// stage input: dividend top bits enter as the starting remainder
		if (k == 0) begin : g_first
			assign vin = in_vld;
			assign rin = DEN_W'(num >> QUO_W);
			assign ain = num[QUO_W-1:0];
			assign din = den;
			assign tin = in_tag;
		end else begin : g_next
			assign vin = vld_s[k];
			assign rin = rem_s[k];
			assign ain = acc_s[k];
			assign din = den_s[k];
			assign tin = tag_s[k];
		end

		// trial subtract, borrow decides the quotient bit
		assign trial = {rin, ain[QUO_W-1]};
		assign diff  = trial - {1'b0, din};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
			acc_s[k+1] <= {ain[QUO_W-2:0], ~diff[DEN_W]};
			den_s[k+1] <= din;
			tag_s[k+1] <= tin;
		end
	end

	assign out_vld = vld_s[QUO_W];
	assign quo     = acc_s[QUO_W];
	assign out_tag = tag_s[QUO_W];

	// the remainder left after the last bit is below the divisor
	`SIP_ASSERT_IMPL(a_rem_below_den, clk, arst_n, vld_s[QUO_W] && (den_s[QUO_W] != '0), rem_s[QUO_W] < den_s[QUO_W])

endmodule

// File: hw/rtl/segment_intersection_point.sv
// Segment crossing test with crossing point. A word is taken at every clock edge where
// start is high; busy never rises, so one word per cycle is sustained. Each result appears,
// in order, on hit, hit_x, hit_y and degenerate for exactly one cycle while done is high.
// The receiver cannot hold results off: it must capture every word marked by done. Each
// word passes six stages of differences, cross products, distances and scaling, then the
// ratio divider, which resolves one quotient bit per pipeline stage (COORD_BITS +
// FRAC_BITS + 1 stages), and one output register. hit_x and hit_y are signed fixed point
// with FRAC_BITS fraction bits; a zero divisor gives a_start and raises degenerate.
`include "segment_intersection_point_macros.svh"

module segment_intersection_point import sip_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [COORD_BITS-1:0]           a_start_x,
	input  logic signed [COORD_BITS-1:0]           a_start_y,
	input  logic signed [COORD_BITS-1:0]           a_end_x,
	input  logic signed [COORD_BITS-1:0]           a_end_y,
	input  logic signed [COORD_BITS-1:0]           b_start_x,
	input  logic signed [COORD_BITS-1:0]           b_start_y,
	input  logic signed [COORD_BITS-1:0]           b_end_x,
	input  logic signed [COORD_BITS-1:0]           b_end_y,
	output logic                                   done,
	output logic                                   hit,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] hit_x,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] hit_y,
	output logic                                   degenerate
);

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int CROSS_W = 2 * DIFF_W + 1;
	localparam int NUM_W   = DIFF_W + CROSS_W + FRAC_BITS + 2;
	localparam int DEN_W   = CROSS_W + 2;
	localparam int QUO_W   = COORD_BITS + FRAC_BITS + 1;
	localparam int OUT_W   = COORD_BITS + FRAC_BITS;
	localparam int LAT     = COORD_BITS + FRAC_BITS + 8;

	typedef struct packed {
		sip_flags_t                   flags;
		logic                         neg;
		logic signed [COORD_BITS-1:0] base;
	} sip_x_tag_t;

	typedef struct packed {
		logic                         neg;
		logic signed [COORD_BITS-1:0] base;
	} sip_y_tag_t;

	localparam int XTAG_W = $bits(sip_x_tag_t);
	localparam int YTAG_W = $bits(sip_y_tag_t);

	// the pipeline never stalls
	assign busy = 1'b0;

	logic                         vld_s3;
	logic signed [CROSS_W-1:0]    ca1_s3, ca2_s3, cb1_s3, cb2_s3;
	logic signed [DIFF_W-1:0]     adx_s3, ady_s3;
	logic signed [COORD_BITS-1:0] asx_s3, asy_s3;

	sip_cross #(
		.COORD_BITS (COORD_BITS)
	) u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start & ~busy),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.vld_s3    (vld_s3),
		.ca1_s3    (ca1_s3),
		.ca2_s3    (ca2_s3),
		.cb1_s3    (cb1_s3),
		.cb2_s3    (cb2_s3),
		.adx_s3    (adx_s3),
		.ady_s3    (ady_s3),
		.asx_s3    (asx_s3),
		.asy_s3    (asy_s3)
	);

	logic                         vld_s6;
	logic [NUM_W-1:0]             num_x_s6, num_y_s6;
	logic [DEN_W-1:0]             den_s6;
	sip_flags_t                   flags_s6;
	logic                         neg_x_s6, neg_y_s6;
	logic signed [COORD_BITS-1:0] asx_s6, asy_s6;

	sip_ratio #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s3   (vld_s3),
		.ca1_s3   (ca1_s3),
		.ca2_s3   (ca2_s3),
		.cb1_s3   (cb1_s3),
		.cb2_s3   (cb2_s3),
		.adx_s3   (adx_s3),
		.ady_s3   (ady_s3),
		.asx_s3   (asx_s3),
		.asy_s3   (asy_s3),
		.vld_s6   (vld_s6),
		.num_x_s6 (num_x_s6),
		.num_y_s6 (num_y_s6),
		.den_s6   (den_s6),
		.flags_s6 (flags_s6),
		.neg_x_s6 (neg_x_s6),
		.neg_y_s6 (neg_y_s6),
		.asx_s6   (asx_s6),
		.asy_s6   (asy_s6)
	);

	sip_x_tag_t       xtag_in, xtag_out;
	sip_y_tag_t       ytag_in, ytag_out;
	logic [XTAG_W-1:0] xtag_vec;
	logic [YTAG_W-1:0] ytag_vec;
	logic             vld_x, vld_y;
	logic [QUO_W-1:0] off_x, off_y;

	assign xtag_in.flags = flags_s6;
	assign xtag_in.neg   = neg_x_s6;
	assign xtag_in.base  = asx_s6;
	assign ytag_in.neg   = neg_y_s6;
	assign ytag_in.base  = asy_s6;

	// offset along x, carries the word flags
	sip_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W),
		.QUO_W (QUO_W),
		.TAG_W (XTAG_W)
	) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s6),
		.num     (num_x_s6),
		.den     (den_s6),
		.in_tag  (xtag_in),
		.out_vld (vld_x),
		.quo     (off_x),
		.out_tag (xtag_vec)
	);

	// offset along y
	sip_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W),
		.QUO_W (QUO_W),
		.TAG_W (YTAG_W)
	) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s6),
		.num     (num_y_s6),
		.den     (den_s6),
		.in_tag  (ytag_in),
		.out_vld (vld_y),
		.quo     (off_y),
		.out_tag (ytag_vec)
	);

	assign xtag_out = sip_x_tag_t'(xtag_vec);
	assign ytag_out = sip_y_tag_t'(ytag_vec);

	// base point in fixed point plus signed offset
	logic [OUT_W:0] base_x_c, base_y_c, pt_x_c, pt_y_c;

	assign base_x_c = (OUT_W + 1)'(xtag_out.base) << FRAC_BITS;
	assign base_y_c = (OUT_W + 1)'(ytag_out.base) << FRAC_BITS;
	assign pt_x_c   = xtag_out.neg ? base_x_c - (OUT_W + 1)'(off_x)
		: base_x_c + (OUT_W + 1)'(off_x);
	assign pt_y_c   = ytag_out.neg ? base_y_c - (OUT_W + 1)'(off_y)
		: base_y_c + (OUT_W + 1)'(off_y);

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_x;
		end
	end

	// output word, zero divisor falls back to a_start
	always_ff @(posedge clk) begin
		hit        <= xtag_out.flags.hit;
		degenerate <= xtag_out.flags.degenerate;
		if (xtag_out.flags.degenerate) begin
			hit_x <= base_x_c[OUT_W-1:0];
			hit_y <= base_y_c[OUT_W-1:0];
		end else begin
			hit_x <= pt_x_c[OUT_W-1:0];
			hit_y <= pt_y_c[OUT_W-1:0];
		end
	end

	// both divider lanes stay in step
	`SIP_ASSERT_IMPL(a_lanes_aligned, clk, arst_n, 1'b1, vld_x == vld_y)
	// a zero divisor means no crossing
	`SIP_ASSERT_IMPL(a_degen_no_hit, clk, arst_n, done, !(hit && degenerate))
	// every word taken comes out after the fixed latency
	`SIP_ASSERT_DELAY(a_fixed_latency, clk, arst_n, start && !busy, LAT, done)

endmodule

// File: verif/sip_checker.sv
`timescale 1ns / 100ps

// watches the word and result channels, predicts each crossing and compares
module sip_checker import sip_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic signed [COORD_BITS-1:0]           a_start_x,
	input  logic signed [COORD_BITS-1:0]           a_start_y,
	input  logic signed [COORD_BITS-1:0]           a_end_x,
	input  logic signed [COORD_BITS-1:0]           a_end_y,
	input  logic signed [COORD_BITS-1:0]           b_start_x,
	input  logic signed [COORD_BITS-1:0]           b_start_y,
	input  logic signed [COORD_BITS-1:0]           b_end_x,
	input  logic signed [COORD_BITS-1:0]           b_end_y,
	input  logic                                   done,
	input  logic                                   hit,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] hit_x,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] hit_y,
	input  logic                                   degenerate,
	output int                                     mismatches,
	output int                                     pending
);

	localparam int OUT_BITS = COORD_BITS + FRAC_BITS;

	typedef struct {
		sip_flags_t            flags;
		logic [OUT_BITS-1:0]   x;
		logic [OUT_BITS-1:0]   y;
	} crossing_t;

	crossing_t crossing_q[$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic logic signed [63:0] cross2d(input logic signed [63:0] ux, uy, vx, vy);
		return ux * vy - uy * vx;
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [63:0] v);
		return (v < 0) ? -v : v;
	endfunction

	// strict sides: both products nonzero with different signs
	function automatic logic opposite(input logic signed [63:0] c1, c2);
		return (c1 != 0) && (c2 != 0) && ((c1 < 0) != (c2 < 0));
	endfunction

	// start + (end - start) * l / sum in fixed point, offset rounded half away from zero
	function automatic logic [OUT_BITS-1:0] lerp_coord(input logic signed [63:0] s, e,
			input logic [63:0] l, sum);
		logic signed [63:0] base;
		logic signed [63:0] d;
		logic [63:0]        m;
		logic [63:0]        off;
		logic [63:0]        point;
		base = s << FRAC_BITS;
		point = base;
		if (sum != 0) begin
			d = e - s;
			m = magnitude(d) * l;
			off = ((m << (FRAC_BITS + 1)) + sum) / (sum << 1);
			point = (d < 0) ? base - off : base + off;
		end
		return point[OUT_BITS-1:0];
	endfunction

	function automatic crossing_t predict_crossing(
			input logic signed [COORD_BITS-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey);
		logic signed [63:0] sx, sy, ex, ey, px, py, qx, qy;
		logic signed [63:0] ca1, ca2, cb1, cb2;
		logic [63:0]        dist_start, dist_sum;
		crossing_t          r;
		sx = asx; sy = asy; ex = aex; ey = aey;
		px = bsx; py = bsy; qx = bex; qy = bey;
		// b endpoints against a, then a endpoints against b
		ca1 = cross2d(ex - sx, ey - sy, px - sx, py - sy);
		ca2 = cross2d(ex - sx, ey - sy, qx - sx, qy - sy);
		cb1 = cross2d(qx - px, qy - py, sx - px, sy - py);
		cb2 = cross2d(qx - px, qy - py, ex - px, ey - py);
		r.flags.hit = opposite(ca1, ca2) && opposite(cb1, cb2);
		dist_start = magnitude(cb1);
		dist_sum = dist_start + magnitude(cb2);
		r.flags.degenerate = (dist_sum == 0);
		r.x = lerp_coord(sx, ex, dist_start, dist_sum);
		r.y = lerp_coord(sy, ey, dist_start, dist_sum);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] sip_checker: %s", $time, msg);
		mismatches++;
	endtask

	// compare results first, then record the word taken at this edge
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n) begin
			if (done) begin
				if (crossing_q.size() == 0) begin
					report_mismatch("result with no word pending");
				end else begin
					want = crossing_q.pop_front();
					if (hit !== want.flags.hit)
						report_mismatch($sformatf("hit %b, want %b", hit, want.flags.hit));
					if (hit_x !== want.x)
						report_mismatch($sformatf("hit_x %h, want %h", hit_x, want.x));
					if (hit_y !== want.y)
						report_mismatch($sformatf("hit_y %h, want %h", hit_y, want.y));
					if (degenerate !== want.flags.degenerate)
						report_mismatch($sformatf("degenerate %b, want %b",
							degenerate, want.flags.degenerate));
				end
			end
			if (start && !busy)
				crossing_q.push_back(predict_crossing(a_start_x, a_start_y, a_end_x, a_end_y,
					b_start_x, b_start_y, b_end_x, b_end_y));
			pending = crossing_q.size();
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
	localparam int LATENCY    = COORD_BITS + FRAC_BITS + 8;
	localparam int RANDOM_WORDS = 500;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic signed [COORD_BITS-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
	logic signed [COORD_BITS-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
	logic                         done;
	logic                         hit;
	logic signed [OUT_BITS-1:0]   hit_x, hit_y;
	logic                         degenerate;
	int                           mismatches;
	int                           pending;
	bit                           idle_enable;

	segment_intersection_point #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
		.done(done), .hit(hit), .hit_x(hit_x), .hit_y(hit_y), .degenerate(degenerate)
	);

	sip_checker #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
		.done(done), .hit(hit), .hit_x(hit_x), .hit_y(hit_y), .degenerate(degenerate),
		.mismatches(mismatches), .pending(pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#200000;
		$display("testbench: done, errors");
		$finish;
	end

	// offer one word, idling at random on falling edges until it is taken
	task automatic send_word(input logic signed [COORD_BITS-1:0] asx, asy, aex, aey,
			bsx, bsy, bex, bey);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (idle_enable && $urandom_range(99) < 21) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				a_start_x <= asx; a_start_y <= asy; a_end_x <= aex; a_end_y <= aey;
				b_start_x <= bsx; b_start_y <= bsy; b_end_x <= bex; b_end_y <= bey;
				@(posedge clk);
				taken = !busy;
			end
		end
	endtask

	// narrow an int to a coordinate
	function automatic logic signed [COORD_BITS-1:0] to_coord(input int v);
		return COORD_BITS'(v);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		return COORD_BITS'($urandom);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] grid_coord();
		return COORD_BITS'(int'($urandom_range(8)) - 4);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] edge_coord();
		case ($urandom_range(4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	// random pair of segments through a shared crossing point; in one form the endpoints mirror around it
	task automatic send_crossing();
		int px, py, ux, uy, vx, vy;
		px = $urandom_range(16000) - 8000;
		py = $urandom_range(16000) - 8000;
		ux = $urandom_range(16000) - 8000;
		uy = $urandom_range(16000) - 8000;
		vx = $urandom_range(16000) - 8000;
		vy = $urandom_range(16000) - 8000;
		if ($urandom_range(1))
			send_word(to_coord(px - ux), to_coord(py - uy), to_coord(px + ux),
				to_coord(py + uy), to_coord(px - vx), to_coord(py - vy),
				to_coord(px + vx), to_coord(py + vy));
		else
			send_word(to_coord(px - ux), to_coord(py - uy), to_coord(px + ux / 3),
				to_coord(py + uy / 3), to_coord(px + vx / 2), to_coord(py + vy / 2),
				to_coord(px - vx), to_coord(py - vy));
	endtask

	initial begin
		int kind;
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		idle_enable = 1'b1;
		a_start_x = '0; a_start_y = '0; a_end_x = '0; a_end_y = '0;
		b_start_x = '0; b_start_y = '0; b_end_x = '0; b_end_y = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words: plain crossing, touching, collinear, parallel, zero divisor
		send_word(0, 0, 10, 10, 0, 10, 10, 0);
		send_word(0, 0, 10, 0, 5, -5, 5, 5);
		send_word(0, 0, 7, 3, 2, -9, 3, 11);
		send_word(0, 0, 10, 0, 10, -5, 10, 5);
		send_word(0, 0, 10, 0, 5, 0, 5, 5);
		send_word(0, 0, 10, 0, 2, 0, 20, 0);
		send_word(0, 0, 10, 0, 0, 3, 10, 3);
		send_word(0, 0, 10, 0, -20, 0, -10, 0);
		send_word(4, 4, 4, 4, 4, 4, 4, 4);
		send_word(1, 2, 9, 7, 5, 5, 5, 5);
		send_word(3, 3, 3, 3, 0, 0, 6, 6);
		send_word(3, 3, 3, 3, 0, 6, 6, 0);
		send_word(0, 0, 1, 1, 0, 1, 1, 0);
		send_word(0, 0, 3, 0, 1, -1, 1, 2);
		send_word(0, 0, -3, 0, -1, -1, -1, 2);
		send_word(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_word(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
		send_word(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		send_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_word(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768);
		send_word(-32768, 32767, 32767, -32768, -1, -1, 0, 0);
		send_word(-1, -1, -1, -1, 0, 0, 0, 0);

		// random words, with one long stretch where the sender never idles
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			idle_enable = !(n >= 200 && n < 330);
			kind = $urandom_range(99);
			if (kind < 45)
				send_crossing();
			else if (kind < 65)
				send_word(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
					grid_coord(), grid_coord(), grid_coord(), grid_coord());
			else if (kind < 85)
				send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord());
			else
				send_word(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
					edge_coord(), edge_coord(), edge_coord(), edge_coord());
		end
		@(negedge clk);
		start <= 1'b0;

		// drain the pipeline
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 20 * LATENCY) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 8) @(negedge clk);
		if (pending != 0)
			$display("testbench: %0d words without a result", pending);

		if (mismatches == 0 && pending == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
